/* rtl/gts_pkg.sv */
// ----------------------------------------------------------------------------
// gts_pkg
// Shared types and constants of the gaze target smoother: action and register
// codes, register bounds and reset values, q1.15 limits, the quotient width and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gts_pkg;

  // action codes of an input transaction
  localparam logic [1:0] ACT_DETECT = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_SMOOTHING    = 3'd2;
  localparam logic [2:0] CFG_DEADBAND     = 3'd3;
  localparam logic [2:0] CFG_MIN_SCORE    = 3'd4;
  localparam logic [2:0] CFG_HOLD_TIME    = 3'd5;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 32;

  // register bounds and reset values
  localparam logic [12:0] FRAME_MAX       = 13'd4096;
  localparam logic [12:0] FRAME_MIN       = 13'd1;
  localparam logic [12:0] WIDTH_RESET     = 13'd640;
  localparam logic [12:0] HEIGHT_RESET    = 13'd480;
  localparam logic [16:0] SMOOTH_MIN      = 17'd655;
  localparam logic [16:0] SMOOTH_MAX      = 17'd65536;
  localparam logic [14:0] DEADBAND_MAX    = 15'd16384;
  localparam logic [16:0] SCORE_MAX       = 17'd65536;

  // q1.15 limits
  localparam logic signed [15:0] Q15_MAX  = 16'sh7fff;
  localparam logic signed [15:0] Q15_MIN  = -16'sh8000;

  // quotient bits produced per axis
  localparam int QUO_BITS = 16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_LOAD,
    S_DIV,
    S_NORM,
    S_BLEND,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

/* rtl/gts_in_if.sv */
// ----------------------------------------------------------------------------
// gts_in_if
// Input channel: detection, tick or clear transaction with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gts_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [COORD_BITS-1:0] box_x;
  logic [COORD_BITS-1:0] box_y;
  logic [15:0]           box_score;
  logic [31:0]           now_ms;

  modport source (output valid, action, box_x, box_y, box_score, now_ms, input ready);
  modport sink   (input valid, action, box_x, box_y, box_score, now_ms, output ready);
endinterface

`default_nettype wire

/* rtl/gts_out_if.sv */
// ----------------------------------------------------------------------------
// gts_out_if
// Output channel: smoothed gaze transaction with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface gts_out_if;
  logic               valid;
  logic               ready;
  logic               gaze_valid;
  logic signed [15:0] gaze_x;
  logic signed [15:0] gaze_y;

  modport source (output valid, gaze_valid, gaze_x, gaze_y, input ready);
  modport sink   (input valid, gaze_valid, gaze_x, gaze_y, output ready);
endinterface

`default_nettype wire

/* rtl/gaze_target_smoother.sv */
// ----------------------------------------------------------------------------
// gaze_target_smoother
// Exponential smoothing of a detected target position with a deadband and a
// hold timeout, built around one shared restoring divider.
// ----------------------------------------------------------------------------
// Usage:
//   item   : input transactions (detection, time tick or clear), valid/ready
//   result : exactly one gaze transaction per input transaction
//   cfg_*  : register writes, to be made by the user only while the block is idle; the block does not enforce it
// Sequencing:
//   a tick or clear loads the result register from the decide state, and the
//   sequencer then returns to idle for the next transaction; a detection
//   passes through the decide state, per axis a load, 16 divider steps and a
//   normalize state, then a blend per axis and a finish state, which loads it.
//   The single serial divider (one quotient bit a cycle) takes most of this path;
//   one transaction is in flight at a time and item.ready is low meanwhile.
// Reset (rst, synchronous): registers return to their defaults, the track is
//   dropped and the result register is emptied.
// Stall: the result is held in an output register until result.ready; a new
//   transaction is accepted once that register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module gaze_target_smoother #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  gts_in_if.sink                                   item,
  gts_out_if.source                                result,
  input  wire logic                                cfg_we,
  input  wire logic [gts_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [gts_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  // width of the signed numerator 2p - w
  localparam int PW = (COORD_BITS + 1 > 13) ? COORD_BITS + 2 : 14;

  // configuration registers
  logic [12:0] img_width;
  logic [12:0] img_height;
  logic [16:0] smoothing_factor;
  logic [14:0] deadband_level;
  logic [16:0] minimum_score;
  logic [31:0] hold_time_ms;

  // tracker state
  logic               track_active;
  logic [31:0]        last_seen_time;
  logic signed [15:0] smoothed_x;
  logic signed [15:0] smoothed_y;

  // latched transaction
  logic [1:0]            act;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [15:0]           score;
  logic [31:0]           now;

  // sequencer and divider
  gts_pkg::state_t state, state_next;
  logic               axis;
  logic [3:0]         cnt;
  logic [13:0]        rem;
  logic [15:0]        quo;
  logic               sat;
  logic               neg;
  logic signed [15:0] aim_x;
  logic signed [15:0] aim_y;

  // control from the sequencer
  logic accept;
  logic is_clear;
  logic is_detect;
  logic timeout;
  logic div_load;
  logic div_step;
  logic norm_store;
  logic blend_step;
  logic finish;
  logic decide_write;

  assign accept = item.valid && item.ready;

  // ---------------------------------------------------------------------------
  // configuration writes, saturated to each register's range
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      img_width        <= gts_pkg::WIDTH_RESET;
      img_height       <= gts_pkg::HEIGHT_RESET;
      smoothing_factor <= gts_pkg::SMOOTH_MAX;
      deadband_level   <= '0;
      minimum_score    <= '0;
      hold_time_ms     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gts_pkg::CFG_FRAME_WIDTH: begin
          if (cfg_data[12:0] < gts_pkg::FRAME_MIN) img_width <= gts_pkg::FRAME_MIN;
          else if (cfg_data[12:0] > gts_pkg::FRAME_MAX) img_width <= gts_pkg::FRAME_MAX;
          else img_width <= cfg_data[12:0];
        end
        gts_pkg::CFG_FRAME_HEIGHT: begin
          if (cfg_data[12:0] < gts_pkg::FRAME_MIN) img_height <= gts_pkg::FRAME_MIN;
          else if (cfg_data[12:0] > gts_pkg::FRAME_MAX) img_height <= gts_pkg::FRAME_MAX;
          else img_height <= cfg_data[12:0];
        end
        gts_pkg::CFG_SMOOTHING: begin
          if (cfg_data[16:0] < gts_pkg::SMOOTH_MIN) smoothing_factor <= gts_pkg::SMOOTH_MIN;
          else if (cfg_data[16:0] > gts_pkg::SMOOTH_MAX) smoothing_factor <= gts_pkg::SMOOTH_MAX;
          else smoothing_factor <= cfg_data[16:0];
        end
        gts_pkg::CFG_DEADBAND: begin
          if (cfg_data[14:0] > gts_pkg::DEADBAND_MAX) deadband_level <= gts_pkg::DEADBAND_MAX;
          else deadband_level <= cfg_data[14:0];
        end
        gts_pkg::CFG_MIN_SCORE: begin
          if (cfg_data[16:0] > gts_pkg::SCORE_MAX) minimum_score <= gts_pkg::SCORE_MAX;
          else minimum_score <= cfg_data[16:0];
        end
        gts_pkg::CFG_HOLD_TIME: hold_time_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // transaction capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= item.action;
      pix_x <= item.box_x;
      pix_y <= item.box_y;
      score <= item.box_score;
      now   <= item.now_ms;
    end
  end

  // action decode
  assign is_clear  = (act == gts_pkg::ACT_CLEAR);
  assign is_detect = (act == gts_pkg::ACT_DETECT) && ({1'b0, score} >= minimum_score);
  assign timeout   = (now - last_seen_time) > hold_time_ms;

  // ---------------------------------------------------------------------------
  // sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      gts_pkg::S_IDLE:   if (accept) state_next = gts_pkg::S_DECIDE;
      gts_pkg::S_DECIDE: state_next = is_detect ? gts_pkg::S_LOAD : gts_pkg::S_IDLE;
      gts_pkg::S_LOAD:   state_next = gts_pkg::S_DIV;
      gts_pkg::S_DIV:    if (cnt == 4'(gts_pkg::QUO_BITS - 1)) state_next = gts_pkg::S_NORM;
      gts_pkg::S_NORM:   state_next = axis ? gts_pkg::S_BLEND : gts_pkg::S_LOAD;
      gts_pkg::S_BLEND:  if (axis) state_next = gts_pkg::S_FINISH;
      gts_pkg::S_FINISH: state_next = gts_pkg::S_IDLE;
      default:           state_next = gts_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    item.ready   = 1'b0;
    decide_write = 1'b0;
    div_load     = 1'b0;
    div_step     = 1'b0;
    norm_store   = 1'b0;
    blend_step   = 1'b0;
    finish       = 1'b0;
    unique case (state)
      gts_pkg::S_IDLE:   item.ready   = !result.valid || result.ready;
      gts_pkg::S_DECIDE: decide_write = !is_detect;
      gts_pkg::S_LOAD:   div_load     = 1'b1;
      gts_pkg::S_DIV:    div_step     = 1'b1;
      gts_pkg::S_NORM:   norm_store   = 1'b1;
      gts_pkg::S_BLEND:  blend_step   = 1'b1;
      gts_pkg::S_FINISH: finish       = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= gts_pkg::S_IDLE;
    else state <= state_next;
  end

  // axis select and step count
  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= 1'b0;
      cnt  <= '0;
    end else begin
      if (state == gts_pkg::S_DECIDE) axis <= 1'b0;
      else if (norm_store && !axis) axis <= 1'b1;
      else if (norm_store && axis) axis <= 1'b0;
      else if (blend_step) axis <= !axis;
      if (div_load) cnt <= '0;
      else if (div_step) cnt <= cnt + 4'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // shared divider: |2p - w| * 2^15 / w, one quotient bit a cycle
  // ---------------------------------------------------------------------------
  logic [COORD_BITS-1:0] pix_sel;
  logic [12:0]           w_sel;
  logic signed [PW-1:0]  num_diff;
  logic [PW-1:0]         num_mag;
  logic                  quo_bit;
  logic [13:0]           rem_keep;

  assign pix_sel  = axis ? pix_y : pix_x;
  assign w_sel    = axis ? img_height : img_width;
  assign num_diff = $signed({{(PW-COORD_BITS-1){1'b0}}, pix_sel, 1'b0})
                  - $signed({{(PW-13){1'b0}}, w_sel});
  assign num_mag  = num_diff[PW-1] ? PW'(-num_diff) : PW'(num_diff);
  assign quo_bit  = rem >= {1'b0, w_sel};
  assign rem_keep = quo_bit ? (rem - {1'b0, w_sel}) : rem;

  always_ff @(posedge clk) begin
    if (div_load) begin
      neg <= num_diff[PW-1];
      // a quotient of 2^16 or more clamps anyway
      sat <= num_mag >= PW'({w_sel, 1'b0});
      rem <= (num_mag >= PW'({w_sel, 1'b0})) ? '0 : num_mag[13:0];
      quo <= '0;
    end else if (div_step) begin
      rem <= {rem_keep[12:0], 1'b0};
      quo <= {quo[14:0], quo_bit};
    end
  end

  // ---------------------------------------------------------------------------
  // clamp to q1.15 and apply the deadband
  // ---------------------------------------------------------------------------
  logic signed [15:0] norm_val;
  logic [16:0]        norm_mag;
  logic signed [15:0] norm_target;

  always_comb begin
    if (neg) begin
      norm_val = quo[15] ? gts_pkg::Q15_MIN : 16'(-{1'b0, quo[14:0]});
      norm_mag = quo[15] ? 17'd32768 : {2'b00, quo[14:0]};
    end else begin
      norm_val = (sat || quo[15]) ? gts_pkg::Q15_MAX : $signed({1'b0, quo[14:0]});
      norm_mag = (sat || quo[15]) ? 17'd32767 : {2'b00, quo[14:0]};
    end
    norm_target = (norm_mag < {2'b00, deadband_level}) ? '0 : norm_val;
  end

  always_ff @(posedge clk) begin
    if (norm_store) begin
      if (axis) aim_y <= norm_target;
      else aim_x <= norm_target;
    end
  end

  // ---------------------------------------------------------------------------
  // blend: cur + floor((target - cur) * factor / 2^16), one axis a cycle
  // ---------------------------------------------------------------------------
  logic signed [15:0] cur_sel;
  logic signed [15:0] tgt_sel;
  logic signed [16:0] blend_diff;
  logic signed [34:0] blend_prod;
  logic signed [19:0] blend_sum;
  logic signed [15:0] blend_out;

  assign cur_sel    = axis ? smoothed_y : smoothed_x;
  assign tgt_sel    = axis ? aim_y : aim_x;
  assign blend_diff = 17'(tgt_sel) - 17'(cur_sel);
  assign blend_prod = 35'(blend_diff) * $signed({1'b0, smoothing_factor});
  assign blend_sum  = 20'(cur_sel) + 20'($signed(blend_prod[34:16]));

  always_comb begin
    if (!track_active) blend_out = tgt_sel;
    else if (blend_sum > 20'(gts_pkg::Q15_MAX)) blend_out = gts_pkg::Q15_MAX;
    else if (blend_sum < 20'(gts_pkg::Q15_MIN)) blend_out = gts_pkg::Q15_MIN;
    else blend_out = blend_sum[15:0];
  end

  // ---------------------------------------------------------------------------
  // tracker state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      track_active   <= 1'b0;
      last_seen_time <= '0;
      smoothed_x     <= '0;
      smoothed_y     <= '0;
    end else if (decide_write && (is_clear || (track_active && timeout))) begin
      track_active   <= 1'b0;
      last_seen_time <= '0;
      smoothed_x     <= '0;
      smoothed_y     <= '0;
    end else if (blend_step) begin
      if (axis) smoothed_y <= blend_out;
      else smoothed_x <= blend_out;
    end else if (finish) begin
      track_active   <= 1'b1;
      last_seen_time <= now;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic report;

  assign report = finish || (decide_write && !is_clear && track_active && !timeout);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (decide_write || finish) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_write || finish) begin
      result.gaze_valid <= report;
      result.gaze_x     <= report ? smoothed_x : '0;
      result.gaze_y     <= report ? smoothed_y : '0;
    end
  end

`ifndef SYNTH
  // a new transaction only enters when the result register can take its result
  assert property (@(posedge clk) disable iff (rst)
    item.ready |-> (!result.valid || result.ready))
    else $error("input accepted while result register is blocked");

  // one transaction in flight
  assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("input ready right after acceptance");

  // an invalid gaze carries zero coordinates
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.gaze_valid) |-> (result.gaze_x == 16'sd0 && result.gaze_y == 16'sd0))
    else $error("invalid gaze with nonzero coordinates");

  // without a track the smoothed gaze rests at zero
  assert property (@(posedge clk) disable iff (rst)
    (state == gts_pkg::S_IDLE && !track_active) |-> (smoothed_x == 16'sd0 && smoothed_y == 16'sd0))
    else $error("smoothed gaze nonzero without a track");
`endif

endmodule

`default_nettype wire
